// ===== hw/rtl/tssl_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// tssl_pkg
// Shared types and constants of the task slot status lists block.
// ---------------------------------------------------------------------------
package tssl_pkg;

    localparam int NUM_SLOTS  = 16;
    localparam int NUM_STATUS = 4;
    localparam int SLOT_W     = 4;
    localparam int LINK_W     = 5;
    localparam int STAT_W     = 2;
    localparam int CNT_W      = 5;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(NUM_SLOTS);
    localparam logic [STAT_W-1:0] TASK_IDLE = '0;

    localparam logic       CMD_QUERY = 1'b0;
    localparam logic       CMD_MOVE  = 1'b1;

    localparam logic [1:0] RES_OK         = 2'd0;
    localparam logic [1:0] RES_BAD_STATUS = 2'd1;
    localparam logic [1:0] RES_BAD_SLOT   = 2'd2;

    typedef struct packed {
        logic       cmd;
        logic [3:0] slot;
        logic [2:0] target_status;
    } cmd_t;

    typedef struct packed {
        logic [1:0] result_code;
        logic [3:0] head_slot;
        logic       list_empty_flag;
        logic [4:0] status_count;
        logic [2:0] previous_status;
    } rsp_t;

    // classified command handed from the front to the back
    typedef struct packed {
        logic [1:0]        code;
        logic              move;
        logic [SLOT_W-1:0] slot;
        logic [STAT_W-1:0] target;
    } op_t;

endpackage
`default_nettype wire

// ===== hw/rtl/tssl_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// tssl_front
// Accepts commands, checks ranges and queues classified operations.
// ---------------------------------------------------------------------------
module tssl_front (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire tssl_pkg::cmd_t  s_data,
    input  wire logic [4:0]      slot_count,
    output logic                 op_valid,
    input  wire logic            op_ready,
    output tssl_pkg::op_t        op_data
);

    tssl_pkg::op_t op_q_reg [tssl_pkg::QUEUE_DEPTH];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] fill_reg;
    tssl_pkg::op_t op_in;
    logic push, pop;

    always_comb begin
        op_in.move   = (s_data.cmd == tssl_pkg::CMD_MOVE);
        op_in.slot   = s_data.slot;
        op_in.target = s_data.target_status[tssl_pkg::STAT_W-1:0];
        if (s_data.target_status >= 3'(tssl_pkg::NUM_STATUS)) begin
            op_in.code = tssl_pkg::RES_BAD_STATUS;
        end else if (op_in.move && ({1'b0, s_data.slot} >= slot_count)) begin
            op_in.code = tssl_pkg::RES_BAD_SLOT;
        end else begin
            op_in.code = tssl_pkg::RES_OK;
        end
    end

    assign s_ready  = (fill_reg != 2'(tssl_pkg::QUEUE_DEPTH));
    assign op_valid = (fill_reg != 2'd0);
    assign op_data  = op_q_reg[rd_ptr_reg];
    assign push = s_valid && s_ready;
    assign pop  = op_valid && op_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push) begin
                op_q_reg[wr_ptr_reg] <= op_in;
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            fill_reg <= fill_reg + 2'(push) - 2'(pop);
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/tssl_back.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// tssl_back
// Holds the linked lists and carries out queries and moves in two steps.
// ---------------------------------------------------------------------------
module tssl_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           init,
    input  wire logic [4:0]     slot_count,
    input  wire logic           op_valid,
    output logic                op_ready,
    input  wire tssl_pkg::op_t  op_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output tssl_pkg::rsp_t      m_data
);
    localparam int NS = tssl_pkg::NUM_SLOTS;
    localparam int NT = tssl_pkg::NUM_STATUS;
    localparam int LW = tssl_pkg::LINK_W;

    typedef enum logic [1:0] {
        ST_READ = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    logic [tssl_pkg::STAT_W-1:0] sstate_reg [NS];
    logic [LW-1:0] next_reg [NS];
    logic [LW-1:0] prev_reg [NS];
    logic [LW-1:0] head_reg [NT];
    logic [LW-1:0] tail_reg [NT];
    logic [tssl_pkg::CNT_W-1:0] cnt_reg [NT];

    tssl_pkg::op_t op_reg;
    logic [tssl_pkg::STAT_W-1:0] st_reg;
    logic [LW-1:0] p_reg, n_reg;

    logic [LW-1:0] h_new [NT];
    logic [LW-1:0] t_new [NT];
    logic [tssl_pkg::CNT_W-1:0] c_new [NT];
    logic [LW-1:0] next_new [NS];
    logic [LW-1:0] prev_new [NS];
    logic [LW-1:0] tl, s5;
    logic do_move;
    tssl_pkg::rsp_t rsp;

    assign op_ready = (state_reg == ST_READ) && (!m_valid || m_ready);

    always_comb begin
        for (int i = 0; i < NT; i++) begin
            h_new[i] = head_reg[i];
            t_new[i] = tail_reg[i];
            c_new[i] = cnt_reg[i];
        end
        for (int i = 0; i < NS; i++) begin
            next_new[i] = next_reg[i];
            prev_new[i] = prev_reg[i];
        end
        s5 = {1'b0, op_reg.slot};
        do_move = op_reg.move && (op_reg.code == tssl_pkg::RES_OK);
        tl = '0;
        if (do_move) begin
            if (p_reg < LW'(NS)) begin
                next_new[p_reg[3:0]] = n_reg;
            end else begin
                h_new[st_reg] = n_reg;
            end
            if (n_reg < LW'(NS)) begin
                prev_new[n_reg[3:0]] = p_reg;
            end else begin
                t_new[st_reg] = p_reg;
            end
            if (c_new[st_reg] != '0) begin
                c_new[st_reg] = c_new[st_reg] - 1'b1;
            end
            tl = t_new[op_reg.target];
            prev_new[op_reg.slot] = tl;
            next_new[op_reg.slot] = tssl_pkg::LINK_NONE;
            if (tl < LW'(NS)) begin
                next_new[tl[3:0]] = s5;
            end else begin
                h_new[op_reg.target] = s5;
            end
            t_new[op_reg.target] = s5;
            c_new[op_reg.target] = c_new[op_reg.target] + 1'b1;
        end
        rsp = '0;
        rsp.result_code = op_reg.code;
        if (op_reg.code == tssl_pkg::RES_OK) begin
            if (c_new[op_reg.target] == '0 || h_new[op_reg.target] >= LW'(NS)) begin
                rsp.list_empty_flag = 1'b1;
            end else begin
                rsp.head_slot = h_new[op_reg.target][3:0];
            end
            rsp.status_count = c_new[op_reg.target];
            rsp.previous_status = do_move ? {1'b0, st_reg} : 3'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || init) begin
            state_reg <= ST_READ;
            m_valid   <= 1'b0;
            for (int i = 0; i < NT; i++) begin
                head_reg[i] <= tssl_pkg::LINK_NONE;
                tail_reg[i] <= tssl_pkg::LINK_NONE;
                cnt_reg[i]  <= '0;
            end
            for (int i = 0; i < NS; i++) begin
                sstate_reg[i] <= tssl_pkg::TASK_IDLE;
                prev_reg[i] <= (i == 0 || LW'(i) >= slot_count) ?
                    tssl_pkg::LINK_NONE : LW'(i - 1);
                next_reg[i] <= (LW'(i + 1) < slot_count) ?
                    LW'(i + 1) : tssl_pkg::LINK_NONE;
            end
            head_reg[tssl_pkg::TASK_IDLE] <= '0;
            tail_reg[tssl_pkg::TASK_IDLE] <= slot_count - 1'b1;
            cnt_reg[tssl_pkg::TASK_IDLE]  <= slot_count;
        end else begin
            if (m_valid && m_ready) begin
                m_valid <= 1'b0;
            end
            unique case (state_reg)
                ST_READ: begin
                    if (op_valid && op_ready) begin
                        op_reg <= op_data;
                        st_reg <= sstate_reg[op_data.slot];
                        p_reg  <= prev_reg[op_data.slot];
                        n_reg  <= next_reg[op_data.slot];
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    for (int i = 0; i < NT; i++) begin
                        head_reg[i] <= h_new[i];
                        tail_reg[i] <= t_new[i];
                        cnt_reg[i]  <= c_new[i];
                    end
                    for (int i = 0; i < NS; i++) begin
                        next_reg[i] <= next_new[i];
                        prev_reg[i] <= prev_new[i];
                    end
                    if (do_move) begin
                        sstate_reg[op_reg.slot] <= op_reg.target;
                    end
                    m_data  <= rsp;
                    m_valid <= 1'b1;
                    state_reg <= ST_READ;
                end
                default: state_reg <= ST_READ;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/task_slot_status_lists.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// task_slot_status_lists
// Task slots kept in per-status FIFO lists with move and query commands.
// ---------------------------------------------------------------------------
// A command in the list engine first reads the slot's links, then updates the
// lists and registers the response, and the engine takes no new command until
// it is through with the last; a two-entry queue parts the checking front from
// the engine. A slot_count write rebuilds all lists in the cycle it is taken.
module task_slot_status_lists (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire tssl_pkg::cmd_t  s_data,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output tssl_pkg::rsp_t       m_data,
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic [4:0]      cfg_data
);

    logic [4:0] slot_count_reg, slot_count_next;
    logic cfg_fire;
    logic op_valid, op_ready;
    tssl_pkg::op_t op_data;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    always_comb begin
        if (cfg_data == 5'd0) begin
            slot_count_next = 5'd1;
        end else if (cfg_data > 5'(tssl_pkg::NUM_SLOTS)) begin
            slot_count_next = 5'(tssl_pkg::NUM_SLOTS);
        end else begin
            slot_count_next = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_count_reg <= 5'(tssl_pkg::NUM_SLOTS);
        end else if (cfg_fire) begin
            slot_count_reg <= slot_count_next;
        end
    end

    tssl_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data,
        .slot_count(slot_count_reg),
        .op_valid, .op_ready, .op_data
    );

    tssl_back u_back (
        .aclk, .aresetn,
        .init(cfg_fire),
        .slot_count(cfg_fire ? slot_count_next : slot_count_reg),
        .op_valid, .op_ready, .op_data,
        .m_valid, .m_ready, .m_data
    );

`ifndef SYNTHESIS
    a_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.result_code == tssl_pkg::RES_OK ||
                     m_data.result_code == tssl_pkg::RES_BAD_STATUS ||
                     m_data.result_code == tssl_pkg::RES_BAD_SLOT))
        else $error("bad result code");
    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.list_empty_flag == (m_data.status_count == 5'd0)
                     || m_data.result_code != tssl_pkg::RES_OK))
        else $error("empty flag and count disagree");
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.status_count <= slot_count_reg))
        else $error("count above slot_count");
`endif

endmodule
`default_nettype wire
